### hdl/rhsv_pkg.sv
// shared types and constants for the rgb/hsv pixel converter
package rhsv_pkg;

    localparam int ChanW      = 8;
    localparam int NumW       = 24;
    localparam int DenW       = 17;
    localparam int QuotW      = 8;
    localparam int Lanes      = 3;
    localparam int DefDivBits = 2;

    localparam logic [ChanW-1:0] ChanMax   = 8'd255;
    localparam logic [DenW-1:0]  FullScale = 17'd65025;

    typedef logic [ChanW-1:0] chan_t;

    // conversion direction
    typedef enum logic {
        DirBgrToHsv = 1'b0,
        DirHsvToBgr = 1'b1
    } dir_t;

    // one divide operation handed to the divider pipeline
    typedef struct packed {
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
    } div_op_t;

    typedef div_op_t [Lanes-1:0] div_ops_t;

endpackage

### hdl/rhsv_front.sv
// front end: channel analysis, sector weights and operand multipliers
module rhsv_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  rhsv_pkg::dir_t    direction,
    input  logic              in_valid,
    output logic              in_ready,
    input  rhsv_pkg::chan_t   chan_a,
    input  rhsv_pkg::chan_t   chan_b,
    input  rhsv_pkg::chan_t   chan_c,
    output logic              out_valid,
    input  logic              out_ready,
    output rhsv_pkg::div_ops_t out_ops
);
    import rhsv_pkg::*;

    // stage handshake
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // ---------------- stage 1 ----------------
    chan_t        mx, mn;
    chan_t        d;
    logic [10:0]  d6;
    logic [10:0]  n1_next;
    logic [10:0]  t;
    logic [2:0]   sector;
    logic [10:0]  p;
    chan_t        f;
    chan_t        wgt1_next [Lanes];

    dir_t         dir1_reg;
    logic [10:0]  n1_reg;
    chan_t        d1_reg, mx1_reg, s1_reg, val1_reg;
    chan_t        wgt1_reg [Lanes];

    // max, min and hue numerator in sixths
    always_comb begin
        mx = chan_c;
        if (chan_b > mx) mx = chan_b;
        if (chan_a > mx) mx = chan_a;
        mn = chan_c;
        if (chan_b < mn) mn = chan_b;
        if (chan_a < mn) mn = chan_a;
        d  = mx - mn;
        d6 = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
        if (mx == chan_c) begin
            if (chan_b >= chan_a) begin
                n1_next = {3'b0, chan_b} - {3'b0, chan_a};
            end else begin
                n1_next = {3'b0, chan_b} + d6 - {3'b0, chan_a};
            end
        end else if (mx == chan_b) begin
            n1_next = {3'b0, chan_a} + {2'b00, d, 1'b0} - {3'b0, chan_c};
        end else begin
            n1_next = {3'b0, chan_c} + {1'b0, d, 2'b00} - {3'b0, chan_b};
        end
    end

    // hue sector and ramp for the hsv direction
    always_comb begin
        t = {1'b0, chan_a, 2'b00} + {2'b00, chan_a, 1'b0};
        sector = 3'(t >= 11'd255) + 3'(t >= 11'd510) + 3'(t >= 11'd765)
               + 3'(t >= 11'd1020) + 3'(t >= 11'd1275) + 3'(t >= 11'd1530);
        case (sector[2:1])
            2'd0:    p = t;
            2'd1:    p = t - 11'd510;
            2'd2:    p = t - 11'd1020;
            default: p = t - 11'd1530;
        endcase
        if (p >= 11'd255) begin
            f = 8'(11'd510 - p);
        end else begin
            f = p[7:0];
        end
        // lanes are blue, green, red
        case (sector)
            3'd0: begin
                wgt1_next[2] = ChanMax; wgt1_next[1] = f;       wgt1_next[0] = '0;
            end
            3'd1: begin
                wgt1_next[2] = f;       wgt1_next[1] = ChanMax; wgt1_next[0] = '0;
            end
            3'd2: begin
                wgt1_next[2] = '0;      wgt1_next[1] = ChanMax; wgt1_next[0] = f;
            end
            3'd3: begin
                wgt1_next[2] = '0;      wgt1_next[1] = f;       wgt1_next[0] = ChanMax;
            end
            3'd4: begin
                wgt1_next[2] = f;       wgt1_next[1] = '0;      wgt1_next[0] = ChanMax;
            end
            default: begin
                wgt1_next[2] = ChanMax; wgt1_next[1] = '0;      wgt1_next[0] = f;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            dir1_reg <= direction;
            n1_reg   <= n1_next;
            d1_reg   <= d;
            mx1_reg  <= mx;
            s1_reg   <= chan_b;
            val1_reg <= chan_c;
            for (int l = 0; l < Lanes; l++) wgt1_reg[l] <= wgt1_next[l];
        end
    end

    // ---------------- stage 2 ----------------
    logic [18:0] hn2_next;
    logic [10:0] hd2_next;
    logic [15:0] sn2_next;
    chan_t       sd2_next;
    logic [15:0] prod2_next [Lanes];

    dir_t        dir2_reg;
    logic [18:0] hn2_reg;
    logic [10:0] hd2_reg;
    logic [15:0] sn2_reg;
    chan_t       sd2_reg, mx2_reg, val2_reg;
    logic [15:0] prod2_reg [Lanes];

    // scale by 255 and form divisors; hsv lanes get s * (255 - w)
    always_comb begin
        hn2_next = {n1_reg, 8'b0} - {8'b0, n1_reg};
        hd2_next = {1'b0, d1_reg, 2'b00} + {2'b00, d1_reg, 1'b0};
        if (d1_reg == '0) begin
            hn2_next = '0;
            hd2_next = 11'd1;
        end
        sn2_next = {d1_reg, 8'b0} - {8'b0, d1_reg};
        sd2_next = (mx1_reg == '0) ? 8'd1 : mx1_reg;
        for (int l = 0; l < Lanes; l++) begin
            prod2_next[l] = {8'b0, s1_reg} * {8'b0, ChanMax - wgt1_reg[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            dir2_reg <= dir1_reg;
            hn2_reg  <= hn2_next;
            hd2_reg  <= hd2_next;
            sn2_reg  <= sn2_next;
            sd2_reg  <= sd2_next;
            mx2_reg  <= mx1_reg;
            val2_reg <= val1_reg;
            for (int l = 0; l < Lanes; l++) prod2_reg[l] <= prod2_next[l];
        end
    end

    // ---------------- stage 3 ----------------
    div_ops_t    ops3_next;
    div_ops_t    ops3_reg;
    logic [DenW-1:0] k;
    logic [24:0] full;

    // hsv lanes: v * (65025 - s * (255 - w)) over 65025
    always_comb begin
        k    = '0;
        full = '0;
        if (dir2_reg == DirBgrToHsv) begin
            ops3_next[0].num = NumW'(hn2_reg);
            ops3_next[0].den = DenW'(hd2_reg);
            ops3_next[1].num = NumW'(sn2_reg);
            ops3_next[1].den = DenW'(sd2_reg);
            ops3_next[2].num = NumW'(mx2_reg);
            ops3_next[2].den = DenW'(1);
        end else begin
            for (int l = 0; l < Lanes; l++) begin
                k    = FullScale - {1'b0, prod2_reg[l]};
                full = {17'b0, val2_reg} * {8'b0, k};
                ops3_next[l].num = full[NumW-1:0];
                ops3_next[l].den = FullScale;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) ops3_reg <= ops3_next;
    end

    assign out_ops = ops3_reg;

    // divisors handed on are never zero
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_ops[0].den != '0 && out_ops[1].den != '0 &&
                       out_ops[2].den != '0))
        else $error("zero divisor handed to divider");

    // hue numerator stays below six times delta
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && dir1_reg == DirBgrToHsv && d1_reg != '0) |-> (n1_reg < hd2_next))
        else $error("hue numerator out of range");

    // every hsv sector has one full channel and one empty channel
    a_sector_weights: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && dir1_reg == DirHsvToBgr) |->
            ((wgt1_reg[0] == ChanMax || wgt1_reg[1] == ChanMax ||
              wgt1_reg[2] == ChanMax) &&
             (wgt1_reg[0] == '0 || wgt1_reg[1] == '0 || wgt1_reg[2] == '0)))
        else $error("sector weights inconsistent");

endmodule

### hdl/rhsv_div.sv
// pipelined restoring divider, three lanes, a few quotient bits per stage
module rhsv_div #(
    parameter int BitsPerStage = rhsv_pkg::DefDivBits
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rhsv_pkg::div_ops_t  in_ops,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [rhsv_pkg::Lanes-1:0][rhsv_pkg::QuotW-1:0] quot
);
    import rhsv_pkg::*;

    localparam int Stages = QuotW / BitsPerStage;
    localparam int TrialW = DenW + QuotW;

    logic [NumW-1:0]  rem_reg [Stages][Lanes];
    logic [DenW-1:0]  den_reg [Stages][Lanes];
    logic [QuotW-1:0] q_reg   [Stages][Lanes];
    logic             v_reg   [Stages];
    logic             rdy     [Stages];

    logic [NumW-1:0]  rem_src [Stages][Lanes];
    logic [DenW-1:0]  den_src [Stages][Lanes];
    logic [QuotW-1:0] q_src   [Stages][Lanes];
    logic             v_src   [Stages];

    for (genvar j = 0; j < Stages; j++) begin : g_stage
        logic [NumW-1:0]  rem_next [Lanes];
        logic [QuotW-1:0] q_next   [Lanes];

        // operands from the input or the stage before
        if (j == 0) begin : g_head
            assign v_src[j] = in_valid;
            for (genvar l = 0; l < Lanes; l++) begin : g_lane
                assign rem_src[j][l] = in_ops[l].num;
                assign den_src[j][l] = in_ops[l].den;
                assign q_src[j][l]   = '0;
            end
        end else begin : g_body
            assign v_src[j] = v_reg[j-1];
            for (genvar l = 0; l < Lanes; l++) begin : g_lane
                assign rem_src[j][l] = rem_reg[j-1][l];
                assign den_src[j][l] = den_reg[j-1][l];
                assign q_src[j][l]   = q_reg[j-1][l];
            end
        end

        // stage may load when empty or when its content moves on
        if (j == Stages - 1) begin : g_tail
            assign rdy[j] = !v_reg[j] || out_ready;
        end else begin : g_mid
            assign rdy[j] = !v_reg[j] || rdy[j+1];
        end

        // trial subtracts for this stage's quotient bits
        always_comb begin
            logic [TrialW-1:0] rem_w;
            logic [TrialW-1:0] trial;
            rem_w = '0;
            trial = '0;
            for (int l = 0; l < Lanes; l++) begin
                rem_w     = TrialW'(rem_src[j][l]);
                q_next[l] = q_src[j][l];
                for (int b = 0; b < BitsPerStage; b++) begin
                    trial = TrialW'(den_src[j][l]) << (QuotW - 1 - j * BitsPerStage - b);
                    if (rem_w >= trial) begin
                        rem_w     = rem_w - trial;
                        q_next[l] = {q_next[l][QuotW-2:0], 1'b1};
                    end else begin
                        q_next[l] = {q_next[l][QuotW-2:0], 1'b0};
                    end
                end
                rem_next[l] = rem_w[NumW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                v_reg[j] <= v_src[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j]) begin
                for (int l = 0; l < Lanes; l++) begin
                    rem_reg[j][l] <= rem_next[l];
                    den_reg[j][l] <= den_src[j][l];
                    q_reg[j][l]   <= q_next[l];
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Stages-1];

    for (genvar l = 0; l < Lanes; l++) begin : g_out
        assign quot[l] = q_reg[Stages-1][l];
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_chk
        // first stage leaves a remainder that the remaining bits can absorb
        a_rem_head: assert property (@(posedge aclk) disable iff (!aresetn)
            v_reg[0] |-> (TrialW'(rem_reg[0][l]) <
                          (TrialW'(den_reg[0][l]) << (QuotW - BitsPerStage))))
            else $error("divider remainder too large after first stage");

        // finished quotient leaves a remainder below the divisor
        a_rem_tail: assert property (@(posedge aclk) disable iff (!aresetn)
            v_reg[Stages-1] |-> (rem_reg[Stages-1][l] < NumW'(den_reg[Stages-1][l])))
            else $error("divider remainder not below divisor");
    end

endmodule

### hdl/rgb_hsv_pixel_converter.sv
// top level of the bgr/hsv pixel converter
// Converts one 8-bit three-channel pixel per clock, while the output is not
// stalled, between BGR and HSV; the direction register (0: BGR to HSV, 1: HSV
// to BGR) is sampled with each pixel as it is accepted. The pipeline takes a
// new pixel every cycle unless the output stalls and delivers results in order:
// three front stages for channel analysis and the operand multipliers, then the
// pipelined restoring divider (two quotient bits per stage by default) that
// produces hue, saturation and value or the three color channels. Each stage
// holds a valid bit and stalls independently, so bubbles are filled while a
// result waits at the output.
module rgb_hsv_pixel_converter #(
    parameter int DivBitsPerStage = rhsv_pkg::DefDivBits
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  rhsv_pkg::chan_t s_chan_first,
    input  rhsv_pkg::chan_t s_chan_second,
    input  rhsv_pkg::chan_t s_chan_third,
    output logic            m_valid,
    input  logic            m_ready,
    output rhsv_pkg::chan_t m_res_first,
    output rhsv_pkg::chan_t m_res_second,
    output rhsv_pkg::chan_t m_res_third
);
    import rhsv_pkg::*;

    dir_t     direction_reg;
    div_ops_t ops;
    logic     ops_valid;
    logic     ops_ready;
    logic [Lanes-1:0][QuotW-1:0] quot;

    // direction register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DirBgrToHsv;
        end else if (cfg_wr_en) begin
            direction_reg <= dir_t'(cfg_wr_data);
        end
    end

    // operand preparation
    rhsv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .direction (direction_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .chan_a    (s_chan_first),
        .chan_b    (s_chan_second),
        .chan_c    (s_chan_third),
        .out_valid (ops_valid),
        .out_ready (ops_ready),
        .out_ops   (ops)
    );

    // divider pipeline
    rhsv_div #(
        .BitsPerStage (DivBitsPerStage)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ops_valid),
        .in_ready  (ops_ready),
        .in_ops    (ops),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .quot      (quot)
    );

    assign m_res_first  = quot[0];
    assign m_res_second = quot[1];
    assign m_res_third  = quot[2];

endmodule
